/* design/pfdt_pkg.sv */
// Shared constants, item types and the token type that travels down the cell chain.
package pfdt_pkg;

  localparam int FRONT_DEPTH    = 64;
  localparam int NUM_OBJECTIVES = 3;
  localparam int COST_WIDTH     = 32;

  localparam int FIELD_WIDTH = 32;
  localparam int COUNT_WIDTH = 7;
  localparam int CNT_W       = $clog2(FRONT_DEPTH + 1);

  // Results wait here between the end of the chain and the output port.
  localparam int QUEUE_DEPTH = 2 ** $clog2(FRONT_DEPTH + 2);
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef logic [COST_WIDTH-1:0] cost_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic                   mode;
    logic [FIELD_WIDTH-1:0] cost_b;
    logic [FIELD_WIDTH-1:0] cost_c;
  } req_item_t;

  typedef struct packed {
    logic                   dominated;
    logic [COUNT_WIDTH-1:0] removed_count;
    logic [COUNT_WIDTH-1:0] front_size;
    logic                   overflow;
  } rsp_item_t;

  typedef struct packed {
    logic  vld;
    logic  mode;
    cost_t b;
    cost_t c;
    logic  placed;
    logic  dominated;
    cnt_t  removed;
    cnt_t  size;
  } token_t;

endpackage

/* design/pfdt_cell.sv */
// One front slot: stores an entry and updates the passing token against it.
module pfdt_cell (
  input  logic            clk,
  input  logic            rst,
  input  pfdt_pkg::token_t tok_in,
  output pfdt_pkg::token_t tok_out
);

  logic            valid;
  logic            valid_next;
  pfdt_pkg::cost_t ent_b;
  pfdt_pkg::cost_t ent_c;
  pfdt_pkg::token_t tok_next;

  logic covers;
  logic covered;
  logic prune;
  logic claim;

  // covers: the entry weakly dominates the token; covered: the reverse
  assign covers  = (ent_b <= tok_in.b) && (ent_c <= tok_in.c);
  assign covered = (tok_in.b <= ent_b) && (tok_in.c <= ent_c);
  assign prune   = tok_in.vld && (tok_in.mode == pfdt_pkg::MODE_INSERT) && valid && covered;
  // lowest free slot after pruning is the first one the insert meets
  assign claim   = tok_in.vld && (tok_in.mode == pfdt_pkg::MODE_INSERT) && !tok_in.placed &&
                   (!valid || prune);

  always_comb begin
    valid_next = (valid && !prune) || claim;
    tok_next   = tok_in;
    if (tok_in.mode == pfdt_pkg::MODE_QUERY) begin
      tok_next.dominated = tok_in.dominated || (valid && covers);
    end
    tok_next.placed  = tok_in.placed || claim;
    tok_next.removed = tok_in.removed + pfdt_pkg::cnt_t'(prune);
    tok_next.size    = tok_in.size + pfdt_pkg::cnt_t'(valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      valid       <= valid_next;
      tok_out.vld <= tok_in.vld;
    end
    if (claim) begin
      ent_b <= tok_in.b;
      ent_c <= tok_in.c;
    end
    tok_out.mode      <= tok_next.mode;
    tok_out.b         <= tok_next.b;
    tok_out.c         <= tok_next.c;
    tok_out.placed    <= tok_next.placed;
    tok_out.dominated <= tok_next.dominated;
    tok_out.removed   <= tok_next.removed;
    tok_out.size      <= tok_next.size;
  end

endmodule

/* design/pfdt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfdt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/pfdt_out_queue.sv */
// Result queue between the end of the cell chain and the response port.
module pfdt_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfdt_pkg::rsp_item_t push_item,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pfdt_pkg::rsp_item_t rsp
);

  logic [pfdt_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [pfdt_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [pfdt_pkg::QUEUE_AW:0]   count;
  logic                          rd_en;
  logic                          rd_vld;
  logic [$bits(pfdt_pkg::rsp_item_t)-1:0] rd_data;

  // one read in flight at a time; it lands only in an empty output register
  assign rd_en = (count != '0) && !rd_vld && (!rsp_valid || rsp_ready);

  pfdt_ram #(
    .WIDTH($bits(pfdt_pkg::rsp_item_t)),
    .DEPTH(pfdt_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(wr_ptr),
    .wr_data(push_item),
    .rd_en  (rd_en),
    .rd_addr(rd_ptr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count  <= count + (pfdt_pkg::QUEUE_AW+1)'(push) - (pfdt_pkg::QUEUE_AW+1)'(rd_en);
      rd_vld <= rd_en;
      if (rd_vld) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (rd_vld) begin
      rsp <= pfdt_pkg::rsp_item_t'(rd_data);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (pfdt_pkg::QUEUE_AW+1)'(pfdt_pkg::QUEUE_DEPTH))
    else $error("result queue overrun");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> rsp_valid)
    else $error("queue read did not reach the output register");

endmodule

/* design/pareto_front_dominance_table_unit.sv */
// Top level of the Pareto front dominance table: cell chain, admission count and result queue.
//
// Each request runs down a chain of FRONT_DEPTH cells, one slot per cell, one cell per cycle;
// a query picks up any stored entry that is no worse on cost_b and cost_c, an insert prunes
// every entry it weakly dominates and lands in the first free slot it meets, and the token
// counts the live entries as it goes. Requests enter the chain back to back and keep their
// order, so each one sees every earlier insert. A result passes the cell registers, the
// queue RAM and its registered read port on the way out; that port keeps one read in
// flight and starts the next only once the last has landed, and req_ready drops while
// QUEUE_DEPTH requests are outstanding. Slots start empty on reset with no clearing pass.
module pareto_front_dominance_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pfdt_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pfdt_pkg::rsp_item_t rsp
);

  pfdt_pkg::token_t tok [pfdt_pkg::FRONT_DEPTH+1];
  pfdt_pkg::token_t tail;
  pfdt_pkg::rsp_item_t tail_item;
  logic [pfdt_pkg::OCC_W-1:0] occ;
  logic req_xfer;
  logic rsp_xfer;

  assign req_ready = occ < pfdt_pkg::OCC_W'(pfdt_pkg::QUEUE_DEPTH);
  assign req_xfer  = req_valid && req_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;

  always_comb begin
    tok[0].vld       = req_xfer;
    tok[0].mode      = req.mode;
    tok[0].b         = pfdt_pkg::cost_t'(req.cost_b);
    tok[0].c         = (pfdt_pkg::NUM_OBJECTIVES > 2) ? pfdt_pkg::cost_t'(req.cost_c) : '0;
    tok[0].placed    = 1'b0;
    tok[0].dominated = 1'b0;
    tok[0].removed   = '0;
    tok[0].size      = '0;
  end

  for (genvar i = 0; i < pfdt_pkg::FRONT_DEPTH; i++) begin : g_cell
    pfdt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  assign tail = tok[pfdt_pkg::FRONT_DEPTH];

  always_comb begin
    tail_item.dominated     = tail.dominated;
    tail_item.removed_count = pfdt_pkg::COUNT_WIDTH'(tail.removed);
    tail_item.front_size    = pfdt_pkg::COUNT_WIDTH'(tail.size);
    tail_item.overflow      = (tail.mode == pfdt_pkg::MODE_INSERT) && !tail.placed;
  end

  pfdt_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (tail.vld),
    .push_item(tail_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // count requests taken whose results have not yet left the port
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + pfdt_pkg::OCC_W'(req_xfer) - pfdt_pkg::OCC_W'(rsp_xfer);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= pfdt_pkg::OCC_W'(pfdt_pkg::QUEUE_DEPTH))
    else $error("outstanding request count out of range");

  a_query_or_insert: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.dominated && (rsp.removed_count != '0 || rsp.overflow)))
    else $error("result mixes query and insert fields");

  a_overflow_no_prune: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.overflow) |-> (rsp.removed_count == '0))
    else $error("dropped insert reports pruned entries");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the Pareto front dominance table: queries, pruning inserts, full store.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class front_scoreboard;
    pfdt_pkg::cost_t     slot_b[pfdt_pkg::FRONT_DEPTH];
    pfdt_pkg::cost_t     slot_c[pfdt_pkg::FRONT_DEPTH];
    bit                  slot_live[pfdt_pkg::FRONT_DEPTH];
    pfdt_pkg::rsp_item_t answers_due[$];
    int                  errors;

    function new();
      foreach (slot_live[s]) slot_live[s] = 1'b0;
      errors = 0;
    endfunction

    // (b1, c1) is no worse than (b2, c2) on every compared objective
    function bit no_worse(pfdt_pkg::cost_t b1, pfdt_pkg::cost_t c1,
                          pfdt_pkg::cost_t b2, pfdt_pkg::cost_t c2);
      return (b1 <= b2) && (pfdt_pkg::NUM_OBJECTIVES < 3 || c1 <= c2);
    endfunction

    function void note_request(pfdt_pkg::req_item_t it);
      pfdt_pkg::cost_t     b;
      pfdt_pkg::cost_t     c;
      pfdt_pkg::rsp_item_t ans;
      int                  removed;
      int                  free_slot;
      int                  live;
      b = pfdt_pkg::cost_t'(it.cost_b);
      c = (pfdt_pkg::NUM_OBJECTIVES > 2) ? pfdt_pkg::cost_t'(it.cost_c) : '0;
      ans = '0;
      removed = 0;
      free_slot = -1;
      live = 0;
      if (it.mode == pfdt_pkg::MODE_QUERY) begin
        foreach (slot_live[s])
          if (slot_live[s] && no_worse(slot_b[s], slot_c[s], b, c)) ans.dominated = 1'b1;
      end else begin
        foreach (slot_live[s]) begin
          if (slot_live[s] && no_worse(b, c, slot_b[s], slot_c[s])) begin
            slot_live[s] = 1'b0;
            removed++;
          end
        end
        for (int s = 0; s < pfdt_pkg::FRONT_DEPTH && free_slot < 0; s++)
          if (!slot_live[s]) free_slot = s;
        if (free_slot >= 0) begin
          slot_b[free_slot] = b;
          slot_c[free_slot] = c;
          slot_live[free_slot] = 1'b1;
        end else begin
          ans.overflow = 1'b1;
        end
      end
      foreach (slot_live[s]) if (slot_live[s]) live++;
      ans.removed_count = pfdt_pkg::COUNT_WIDTH'(removed);
      ans.front_size = pfdt_pkg::COUNT_WIDTH'(live);
      answers_due = {answers_due, ans};
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pfdt_pkg::rsp_item_t got);
      pfdt_pkg::rsp_item_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      compare_field("dominated", want.dominated, got.dominated);
      compare_field("removed_count", want.removed_count, got.removed_count);
      compare_field("front_size", want.front_size, got.front_size);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  pfdt_pkg::req_item_t req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  pfdt_pkg::rsp_item_t rsp;

  front_scoreboard book = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  pareto_front_dominance_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: take results, stall at random, and hold off once for a long stretch.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) book.check_result(rsp);
    if (hold_armed && !hold_done) begin
      hold_left = 600;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic pfdt_pkg::req_item_t make_item(logic mode, pfdt_pkg::cost_t b,
                                                     pfdt_pkg::cost_t c);
    pfdt_pkg::req_item_t it;
    it = '0;
    it.mode = mode;
    it.cost_b = b;
    it.cost_c = c;
    return it;
  endfunction

  function automatic pfdt_pkg::cost_t pick_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {pfdt_pkg::COST_WIDTH{1'b1}};
      2, 3, 4, 5, 6: return pfdt_pkg::cost_t'($urandom_range(0, 15));
      7: return {pfdt_pkg::COST_WIDTH{1'b1}} - pfdt_pkg::cost_t'($urandom_range(0, 15));
      default: return pfdt_pkg::cost_t'($urandom);
    endcase
  endfunction

  // Call just after a rising edge; returns at the edge where the transfer happens.
  task automatic send_item(pfdt_pkg::req_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    book.note_request(it);
    items_sent++;
  endtask

  // Grow an antichain until the store overflows, then prune its upper half.
  task automatic fill_front();
    pfdt_pkg::cost_t b;
    pfdt_pkg::cost_t c;
    b = pfdt_pkg::cost_t'($urandom_range(1, 1000));
    c = {pfdt_pkg::COST_WIDTH{1'b1}} - pfdt_pkg::cost_t'($urandom_range(0, 1000));
    for (int n = 0; n < 72; n++) begin
      send_item(make_item(pfdt_pkg::MODE_INSERT, b, c));
      if ($urandom_range(0, 7) == 0)
        send_item(make_item(pfdt_pkg::MODE_QUERY, pick_cost(), pick_cost()));
      b += pfdt_pkg::cost_t'($urandom_range(1, 1000));
      c -= pfdt_pkg::cost_t'($urandom_range(1, 1000));
    end
    send_item(make_item(pfdt_pkg::MODE_INSERT, b >> 1, c));
  endtask

  task automatic run_phase(int target);
    int  phase_end;
    bit  filled;
    phase_end = items_sent + target;
    filled = 1'b0;
    while (items_sent < phase_end) begin
      if (!filled && $urandom_range(0, 39) == 0) begin
        fill_front();
        filled = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        send_item(make_item(pfdt_pkg::MODE_INSERT, '0, '0));
      end else begin
        send_item(make_item(($urandom_range(0, 99) < 45) ? pfdt_pkg::MODE_INSERT
                                                         : pfdt_pkg::MODE_QUERY,
                            pick_cost(), pick_cost()));
      end
    end
    if (!filled) fill_front();
  endtask

  initial begin
    pfdt_pkg::cost_t top;
    top = {pfdt_pkg::COST_WIDTH{1'b1}};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 66;
    // empty front, equal vectors, extremes, prune-all
    send_item(make_item(pfdt_pkg::MODE_QUERY, '0, '0));
    send_item(make_item(pfdt_pkg::MODE_QUERY, top, top));
    send_item(make_item(pfdt_pkg::MODE_INSERT, 5, 5));
    send_item(make_item(pfdt_pkg::MODE_QUERY, 5, 5));
    send_item(make_item(pfdt_pkg::MODE_QUERY, 4, 5));
    send_item(make_item(pfdt_pkg::MODE_QUERY, 5, 4));
    send_item(make_item(pfdt_pkg::MODE_QUERY, top, top));
    send_item(make_item(pfdt_pkg::MODE_INSERT, 5, 5));
    send_item(make_item(pfdt_pkg::MODE_INSERT, 3, 7));
    send_item(make_item(pfdt_pkg::MODE_INSERT, 7, 3));
    send_item(make_item(pfdt_pkg::MODE_QUERY, 4, 6));
    send_item(make_item(pfdt_pkg::MODE_INSERT, '0, top));
    send_item(make_item(pfdt_pkg::MODE_INSERT, top, '0));
    send_item(make_item(pfdt_pkg::MODE_QUERY, '0, '0));
    send_item(make_item(pfdt_pkg::MODE_INSERT, top, top));
    send_item(make_item(pfdt_pkg::MODE_INSERT, '0, '0));
    send_item(make_item(pfdt_pkg::MODE_QUERY, '0, '0));
    send_item(make_item(pfdt_pkg::MODE_INSERT, 32'hAAAA_AAAA, 32'h5555_5555));
    send_item(make_item(pfdt_pkg::MODE_QUERY, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(make_item(pfdt_pkg::MODE_QUERY, top, 32'h5555_5555));
    send_item(make_item(pfdt_pkg::MODE_INSERT, '0, '0));
    run_phase(165);

    send_idle_pct = 66;
    recv_idle_pct = 14;
    run_phase(180);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed = 1'b1;
    run_phase(180);
    req_valid <= 1'b0;

    while (book.answers_due.size() != 0) @(posedge clk);
    repeat (pfdt_pkg::FRONT_DEPTH + 16) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pfdt_pkg.sv
design/pfdt_cell.sv
design/pfdt_ram.sv
design/pfdt_out_queue.sv
design/pareto_front_dominance_table_unit.sv
tb/tb_top.sv
